// ===== sv/mat_pkg.sv =====
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants for the MAC activity tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mat_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int MAC_W       = 48;
   localparam int STAMP_W     = 32;
   localparam int COUNT_W     = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam int REQ_DATA_W  = 2 * MAC_W + STAMP_W;
   localparam int RSP_FIELD_W = 1 + 2 * COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOOF_WINDOW  = 1'b1;

   typedef enum logic {
      OP_RECORD  = 1'b0,
      OP_ANALYZE = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_WRITE  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== sv/mac_activity_tracker_top.sv =====
// ----------------------------------------------------------------------------
// mac_activity_tracker_top
// Table of recent MAC addresses with last-seen times; record and analyze items.
// ----------------------------------------------------------------------------
// Sequence: after an item is accepted the walk reads one table entry per cycle
//   over all 32; a record item then writes the table in ST_WRITE, and both kinds end in ST_FINISH.
// A new item is accepted only in ST_IDLE, after ST_FINISH has loaded the previous response.
// Reset: synchronous, active high; empties the table (valid bits), clears the
//   replace pointer and both window registers.
`default_nettype none

module mac_activity_tracker_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: first_mac[47:0], second_mac[95:48], stamp[127:96]
   input  wire logic [mat_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: opcode[0]
   input  wire logic                             req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // rsp_tdata: spoof_flag[0], active_count[6:1], target_hits[12:7], zero pad
   output logic [mat_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mat_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mat_pkg::*;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             ptr_ff, ptr_in;
   opcode_type                   op_ff;
   logic [MAC_W-1:0]             first_ff, second_ff;
   logic [STAMP_W-1:0]           stamp_ff;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             hit_idx_ff, hit_idx_in;
   logic                         spoof_ff, spoof_in;
   logic [COUNT_W-1:0]           active_ff, active_in;
   logic [COUNT_W-1:0]           hits_ff, hits_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]        rsp_data_ff;
   logic [STAMP_W-1:0]           act_win_ff, spf_win_ff;
   logic [TABLE_DEPTH-1:0]       valid_ff;

   logic [MAC_W-1:0]             addr_mem [TABLE_DEPTH];
   logic [STAMP_W-1:0]           time_mem [TABLE_DEPTH];

   logic                         req_acc;
   logic                         walk_last;
   logic [MAC_W-1:0]             rd_addr;
   logic [STAMP_W-1:0]           rd_time;
   logic [STAMP_W-1:0]           age;
   logic                         occupied;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic                         rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign walk_last  = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign rd_addr    = valid_ff[idx_ff] ? addr_mem[idx_ff] : '0;
   assign rd_time    = valid_ff[idx_ff] ? time_mem[idx_ff] : '0;
   assign age        = stamp_ff - rd_time;
   assign occupied   = (rd_time != '0);

   assign wr_en      = (state_ff == ST_WRITE);
   assign wr_idx     = found_ff ? hit_idx_ff : ptr_ff;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      ptr_in     = ptr_ff;
      found_in   = found_ff;
      hit_idx_in = hit_idx_ff;
      spoof_in   = spoof_ff;
      active_in  = active_ff;
      hits_in    = hits_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in  = ST_WALK;
               idx_in    = '0;
               found_in  = 1'b0;
               spoof_in  = 1'b0;
               active_in = '0;
               hits_in   = '0;
            end
         end
         ST_WALK: begin
            if (op_ff == OP_RECORD) begin
               if (!found_ff && rd_addr == first_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = idx_ff;
               end
            end else if (occupied) begin
               if (age < act_win_ff && active_ff != COUNT_MAX) begin
                  active_in = active_ff + 1'b1;
               end
               if (rd_addr == first_ff && age < spf_win_ff) begin
                  spoof_in = 1'b1;
               end
               if (rd_addr == second_ff && hits_ff != COUNT_MAX) begin
                  hits_in = hits_ff + 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (walk_last) begin
               state_in = (op_ff == OP_RECORD) ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            if (!found_ff) begin
               ptr_in = (ptr_ff == IDX_W'(TABLE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         act_win_ff   <= '0;
         spf_win_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACTIVE_WINDOW: act_win_ff <= csr_data;
               CSR_SPOOF_WINDOW:  spf_win_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      hit_idx_ff <= hit_idx_in;
      spoof_ff   <= spoof_in;
      active_ff  <= active_in;
      hits_ff    <= hits_in;
      if (req_acc) begin
         op_ff     <= opcode_type'(req_tuser);
         first_ff  <= req_tdata[MAC_W-1:0];
         second_ff <= req_tdata[2*MAC_W-1:MAC_W];
         stamp_ff  <= req_tdata[REQ_DATA_W-1:2*MAC_W];
      end
      if (rsp_load) begin
         rsp_data_ff <= {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, hits_ff, active_ff, spoof_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= first_ff;
         time_mem[wr_idx] <= stamp_ff;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mat_checker.sv =====
// ----------------------------------------------------------------------------
// mat_checker
// Port-level checks for the MAC activity tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mat_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [mat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready
);
   import mat_pkg::*;

   // a held result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // the table walk keeps req_tready low after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("req accepted again during table walk");

   // counts never exceed the table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COUNT_W:1] <= COUNT_W'(TABLE_DEPTH)
                  && rsp_tdata[2*COUNT_W:COUNT_W+1] <= COUNT_W'(TABLE_DEPTH))
      else $error("rsp count above table depth");

   // padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W] == '0)
      else $error("rsp padding not zero");

endmodule

bind mac_activity_tracker_top mat_checker u_mat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
